// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [31:0] request_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } rsp_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_BLOCK = 2'd1;
  localparam logic [1:0] STS_BAD_REQ  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/bpa_ram.sv
`default_nettype none

module bpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/buddy_page_allocator_unit.sv
// Channel  Direction  Signals                          Payload
// request  in         req_valid_i / req_stall_o        bpa_pkg::req_t
// response out        rsp_valid_o / rsp_stall_i        bpa_pkg::rsp_t
//
// One request at a time. Allocate: decode, list search from the request's
// order upward, unlink, then a push per split level. Free: decode, free
// mark check, a buddy check and unlink per merge level, then the final push.
// Steps that read the free mark (with order) or link memories wait on the
// registered read. After reset the free mark memory is swept clean with
// req_stall_o high. A stalled response is held in the output register
// while the next request is already being worked on.
`default_nettype none
`include "assert_macros.svh"

module buddy_page_allocator_unit #(
  parameter int NUM_ORDERS = 11,
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire bpa_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output bpa_pkg::rsp_t      rsp_o
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int PW = $clog2(NUM_PAGES + 1);
  localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int CW = $clog2(NUM_ORDERS + 1);
  localparam int XW = ((PW > NUM_ORDERS) ? PW : NUM_ORDERS) + 1;
  localparam int MW = OW + 1;
  localparam logic [PW-1:0] EMPTY = PW'(NUM_PAGES);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FIND   = 4'd3;
  localparam logic [3:0] S_UNLINK = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_PUSHA  = 4'd6;
  localparam logic [3:0] S_PUSHB  = 4'd7;
  localparam logic [3:0] S_FMCHK  = 4'd8;
  localparam logic [3:0] S_BUD    = 4'd9;
  localparam logic [3:0] S_BUDCHK = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic          cmd_q;
  logic [31:0]   size_q, addr_q;
  logic [CW-1:0] ord_q, ord_d, cur_q, cur_d;
  logic [AW-1:0] pfn_q, pfn_d, node_q, node_d, clr_q, clr_d;
  logic [PW-1:0] nx_q, nx_d;
  logic [PW-1:0] head_q [NUM_ORDERS];
  bpa_pkg::rsp_t res_q, res_d, rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic          head_we;
  logic [OW-1:0] head_wa;
  logic [PW-1:0] head_wd;

  logic          mark_we, next_we, prev_we;
  logic [AW-1:0] mark_wa, next_wa, prev_wa, mark_ra, link_ra;
  logic [MW-1:0] mark_wd, mark_rd;
  logic [PW-1:0] next_wd, prev_wd, next_rd, prev_rd;

  logic          req_fire;
  logic [CW-1:0] ord_calc;
  logic [PW-1:0] head_cur;

  assign req_stall_o = (state_q != S_IDLE);
  assign req_fire    = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign head_cur    = head_q[cur_q[OW-1:0]];

  bpa_ram #(.Width(MW), .Depth(NUM_PAGES)) u_mark_ram (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(mark_ra), .rdata_o(mark_rd)
  );
  bpa_ram #(.Width(PW), .Depth(NUM_PAGES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(link_ra), .rdata_o(next_rd)
  );
  bpa_ram #(.Width(PW), .Depth(NUM_PAGES)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(link_ra), .rdata_o(prev_rd)
  );

  // Smallest order whose block holds the size; NUM_ORDERS when none does.
  always_comb begin
    ord_calc = CW'(NUM_ORDERS);
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if ({1'b0, size_q} <= (33'd1 << (PAGE_SHIFT + k))) begin
        ord_calc = CW'(k);
      end
    end
  end

  always_comb begin
    logic [32:0]   amask;
    logic [31:0]   pfn_full;
    logic [33:0]   end_sum;
    logic [XW-1:0] bud_x, right_x, pfn_x;
    logic [CW-1:0] cur_m1;
    state_d = state_q;
    ord_d   = ord_q;
    cur_d   = cur_q;
    pfn_d   = pfn_q;
    node_d  = node_q;
    nx_d    = nx_q;
    clr_d   = clr_q;
    res_d   = res_q;
    rsp_d   = rsp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    head_we = 1'b0;
    head_wa = cur_q[OW-1:0];
    head_wd = EMPTY;
    mark_we = 1'b0;
    mark_wa = node_q;
    mark_wd = '0;
    mark_ra = node_q;
    next_we = 1'b0;
    next_wa = node_q;
    next_wd = EMPTY;
    prev_we = 1'b0;
    prev_wa = node_q;
    prev_wd = EMPTY;
    link_ra = node_q;
    amask    = (33'd1 << (PAGE_SHIFT + 32'(ord_calc))) - 33'd1;
    pfn_full = addr_q >> PAGE_SHIFT;
    end_sum  = {2'b00, pfn_full} + (34'd1 << ord_calc);
    bud_x    = XW'(pfn_q) ^ (XW'(1) << ord_q);
    pfn_x    = XW'(pfn_q) & ~((XW'(2) << ord_q) - XW'(1));
    cur_m1   = cur_q - CW'(1);
    right_x  = XW'(pfn_q) + (XW'(1) << cur_m1);

    unique case (state_q)
      S_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d = '{block_address: 32'd0, status: bpa_pkg::STS_OK};
        ord_d = ord_calc;
        cur_d = ord_calc;
        pfn_d = pfn_full[AW-1:0];
        mark_ra = pfn_full[AW-1:0];
        if (ord_calc == CW'(NUM_ORDERS)) begin
          res_d.status = bpa_pkg::STS_BAD_REQ;
          state_d = S_DONE;
        end else if (cmd_q == bpa_pkg::CMD_ALLOC) begin
          state_d = S_FIND;
        end else if ((|({1'b0, addr_q} & amask)) || (end_sum > 34'(NUM_PAGES))) begin
          res_d.status = bpa_pkg::STS_BAD_REQ;
          state_d = S_DONE;
        end else begin
          state_d = S_FMCHK;
        end
      end
      S_FIND: begin
        if (cur_q == CW'(NUM_ORDERS)) begin
          res_d.status = bpa_pkg::STS_NO_BLOCK;
          state_d = S_DONE;
        end else if (head_cur == EMPTY) begin
          cur_d = cur_q + CW'(1);
        end else begin
          node_d  = head_cur[AW-1:0];
          link_ra = head_cur[AW-1:0];
          state_d = S_UNLINK;
        end
      end
      S_UNLINK: begin
        // Link data for node_q arrives now; splice it out of its list.
        if (prev_rd < EMPTY) begin
          next_we = 1'b1;
          next_wa = prev_rd[AW-1:0];
          next_wd = next_rd;
        end else begin
          head_we = 1'b1;
          head_wd = next_rd;
        end
        if (next_rd < EMPTY) begin
          prev_we = 1'b1;
          prev_wa = next_rd[AW-1:0];
          prev_wd = prev_rd;
        end
        mark_we = 1'b1;
        if (cmd_q == bpa_pkg::CMD_ALLOC) begin
          pfn_d   = node_q;
          state_d = S_SPLIT;
        end else begin
          pfn_d   = pfn_x[AW-1:0];
          ord_d   = ord_q + CW'(1);
          cur_d   = cur_q + CW'(1);
          state_d = S_BUD;
        end
      end
      S_SPLIT: begin
        if (cur_q > ord_q) begin
          cur_d = cur_m1;
          if (right_x < XW'(NUM_PAGES)) begin
            node_d  = right_x[AW-1:0];
            state_d = S_PUSHA;
          end
        end else begin
          res_d.block_address = 32'(64'(pfn_q) << PAGE_SHIFT);
          state_d = S_DONE;
        end
      end
      S_PUSHA: begin
        next_we = 1'b1;
        next_wd = head_cur;
        prev_we = 1'b1;
        mark_we = 1'b1;
        mark_wd = {1'b1, cur_q[OW-1:0]};
        head_we = 1'b1;
        head_wd = PW'(node_q);
        nx_d    = head_cur;
        state_d = S_PUSHB;
      end
      S_PUSHB: begin
        if (nx_q < EMPTY) begin
          prev_we = 1'b1;
          prev_wa = nx_q[AW-1:0];
          prev_wd = PW'(node_q);
        end
        state_d = (cmd_q == bpa_pkg::CMD_ALLOC) ? S_SPLIT : S_DONE;
      end
      S_FMCHK: begin
        if (mark_rd[OW]) begin
          res_d.status = bpa_pkg::STS_BAD_REQ;
          state_d = S_DONE;
        end else begin
          state_d = S_BUD;
        end
      end
      S_BUD: begin
        if ((({1'b0, ord_q} + 1'b1) >= (CW + 1)'(NUM_ORDERS)) ||
            (bud_x >= XW'(NUM_PAGES))) begin
          node_d  = pfn_q;
          state_d = S_PUSHA;
        end else begin
          node_d  = bud_x[AW-1:0];
          mark_ra = bud_x[AW-1:0];
          state_d = S_BUDCHK;
        end
      end
      S_BUDCHK: begin
        if (mark_rd[OW] && (mark_rd[OW-1:0] == ord_q[OW-1:0])) begin
          link_ra = node_q;
          state_d = S_UNLINK;
        end else begin
          node_d  = pfn_q;
          state_d = S_PUSHA;
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_q[i] <= EMPTY;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      if (head_we) begin
        head_q[head_wa] <= head_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q  <= req_i.command;
      size_q <= req_i.request_size;
      addr_q <= req_i.request_address;
    end
    ord_q  <= ord_d;
    cur_q  <= cur_d;
    pfn_q  <= pfn_d;
    node_q <= node_d;
    nx_q   <= nx_d;
    res_q  <= res_d;
    rsp_q  <= rsp_d;
  end

  `BPA_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_fire, req_stall_o, "request not held busy")
  `BPA_ASSERT_NOW(a_err_no_addr, clk_i, rst_ni, rsp_valid_o && (rsp_o.status != bpa_pkg::STS_OK), rsp_o.block_address == 32'd0, "address on failed request")
  `BPA_ASSERT_NEXT(a_push_pair, clk_i, rst_ni, state_q == S_PUSHA, state_q == S_PUSHB, "push split broken")
  `BPA_ASSERT_NOW(a_unlink_src, clk_i, rst_ni, state_q == S_UNLINK, $past(state_q) == S_FIND || $past(state_q) == S_BUDCHK, "unlink without link read")

endmodule

`default_nettype wire

// File: bench/buddy_page_allocator_checker.sv
`timescale 1ns / 1ps

module buddy_page_allocator_checker #(
  parameter int NUM_ORDERS = 11,
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_stall_i,
  input  bpa_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_stall_i,
  input  bpa_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int EMPTY = NUM_PAGES;

  bit            free_mark [NUM_PAGES];
  bit [3:0]      head_order[NUM_PAGES];
  int            next_pg   [NUM_PAGES];
  int            prev_pg   [NUM_PAGES];
  int            list_first[NUM_ORDERS];
  bpa_pkg::rsp_t expected_rsp_q[$];
  int            fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_rsp_q.size();

  function automatic int order_of_size(logic [31:0] size);
    int k;
    k = 0;
    while (k < NUM_ORDERS && {32'd0, size} > (64'd1 << (PAGE_SHIFT + k))) k++;
    return k;
  endfunction

  function automatic void push_free(int p, int k);
    int nx;
    nx = list_first[k];
    next_pg[p] = nx;
    prev_pg[p] = EMPTY;
    if (nx < NUM_PAGES) prev_pg[nx] = p;
    list_first[k] = p;
    free_mark[p]  = 1'b1;
    head_order[p] = k[3:0];
  endfunction

  function automatic void unlink_free(int p, int k);
    int nx, pv;
    nx = next_pg[p];
    pv = prev_pg[p];
    if (pv < NUM_PAGES) next_pg[pv] = nx;
    else list_first[k] = nx;
    if (nx < NUM_PAGES) prev_pg[nx] = pv;
    free_mark[p] = 1'b0;
  endfunction

  function automatic bpa_pkg::rsp_t predict_response(bpa_pkg::req_t r);
    bpa_pkg::rsp_t o;
    int       k, cur, pfn, bud;
    longint   right, pfn64;
    logic [63:0] bytes;
    o.block_address = '0;
    o.status        = bpa_pkg::STS_OK;
    k = order_of_size(r.request_size);
    if (k >= NUM_ORDERS) begin
      o.status = bpa_pkg::STS_BAD_REQ;
      return o;
    end
    if (r.command == bpa_pkg::CMD_ALLOC) begin
      cur = k;
      while (cur < NUM_ORDERS && list_first[cur] >= NUM_PAGES) cur++;
      if (cur >= NUM_ORDERS) begin
        o.status = bpa_pkg::STS_NO_BLOCK;
        return o;
      end
      pfn = list_first[cur];
      unlink_free(pfn, cur);
      while (cur > k) begin
        cur--;
        right = longint'(pfn) + (longint'(1) << cur);
        if (right < NUM_PAGES) push_free(int'(right), cur);
      end
      o.block_address = 32'(longint'(pfn) << PAGE_SHIFT);
      return o;
    end
    bytes = 64'd1 << (PAGE_SHIFT + k);
    pfn64 = longint'(r.request_address >> PAGE_SHIFT);
    if (({32'd0, r.request_address} & (bytes - 64'd1)) != 0 ||
        pfn64 + (longint'(1) << k) > NUM_PAGES) begin
      o.status = bpa_pkg::STS_BAD_REQ;
      return o;
    end
    pfn = int'(pfn64);
    if (free_mark[pfn]) begin
      o.status = bpa_pkg::STS_BAD_REQ;
      return o;
    end
    while (k + 1 < NUM_ORDERS) begin
      bud = pfn ^ (1 << k);
      if (bud >= NUM_PAGES || !free_mark[bud] || head_order[bud] != k[3:0]) break;
      unlink_free(bud, k);
      pfn = pfn & ~((2 << k) - 1);
      k++;
    end
    push_free(pfn, k);
    return o;
  endfunction

  initial begin
    fail_count = 0;
    foreach (free_mark[i]) free_mark[i] = 1'b0;
    foreach (list_first[i]) list_first[i] = EMPTY;
  end

  always @(posedge clk_i) begin
    bpa_pkg::rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response addr=%h status=%0d", $time,
                   rsp_i.block_address, rsp_i.status);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.block_address !== want.block_address) begin
            $display("%0t: block_address expected %h actual %h", $time,
                     want.block_address, rsp_i.block_address);
            fail_count++;
          end
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_i.status);
            fail_count++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) expected_rsp_q.push_back(predict_response(req_i));
    end
  end
endmodule

// File: bench/buddy_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module buddy_page_allocator_unit_tb;

  localparam int  RANDOM_REQS = 1530;
  localparam int  CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] addr;
    int          ord;
  } owned_blk_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  req_valid_i = 1'b0;
  logic  req_stall_o;
  bpa_pkg::req_t req_i = '0;
  logic  rsp_valid_o;
  logic  rsp_stall_i = 1'b0;
  bpa_pkg::rsp_t rsp_o;
  int    fail_count, pending;
  int    cycle_cnt = 0;
  int    rsp_hold = 0;
  bit    quiet = 1'b0;
  int    sent = 0;
  bpa_pkg::req_t inflight_q[$];
  owned_blk_t owned_q[$];
  owned_blk_t last_freed;

  always #1 clk_i = ~clk_i;

  buddy_page_allocator_unit i_dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o
  );

  buddy_page_allocator_checker i_checker (
    .clk_i, .rst_ni,
    .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_stall_i, .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int size_order(logic [31:0] size);
    int k;
    k = 0;
    while (k < 11 && {32'd0, size} > (64'd1 << (12 + k))) k++;
    return k;
  endfunction

  function automatic logic [31:0] size_in_order(int k);
    if (k == 0) return $urandom_range(0, 4096);
    return $urandom_range((1 << (11 + k)) + 1, 1 << (12 + k));
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("buddy_page_allocator_unit test failed");
      $finish;
    end
  end

  // track granted blocks so they can be handed back later
  always @(posedge clk_i) begin
    bpa_pkg::req_t r;
    owned_blk_t b;
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        r = inflight_q.pop_front();
        if (r.command == bpa_pkg::CMD_ALLOC && rsp_o.status == bpa_pkg::STS_OK) begin
          b.addr = rsp_o.block_address;
          b.ord  = size_order(r.request_size);
          owned_q.push_back(b);
        end
        rsp_hold <= quiet ? 0 : $urandom_range(0, 4);
      end else if (rsp_valid_o && rsp_hold > 0) begin
        rsp_hold <= rsp_hold - 1;
      end
      if (req_valid_i && !req_stall_o) inflight_q.push_back(req_i);
    end
  end

  always @(negedge clk_i) rsp_stall_i <= (rsp_hold != 0);

  task automatic send(logic cmd, logic [31:0] size, logic [31:0] addr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{command: cmd, request_size: size, request_address: addr};
    do @(posedge clk_i); while (req_stall_o);
    sent++;
  endtask

  task automatic free_owned();
    int idx;
    owned_blk_t b;
    idx = $urandom_range(0, owned_q.size() - 1);
    b = owned_q[idx];
    owned_q.delete(idx);
    last_freed = b;
    send(bpa_pkg::CMD_FREE, size_in_order(b.ord), b.addr);
  endtask

  initial begin
    int k;
    last_freed = '{addr: 32'd0, ord: 0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // nothing is free after reset; malformed frees are refused
    send(bpa_pkg::CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send(bpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(bpa_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'd0);
    send(bpa_pkg::CMD_FREE, 32'h0040_0001, 32'd0);
    send(bpa_pkg::CMD_FREE, 32'd0, 32'hFFFF_F000);
    send(bpa_pkg::CMD_FREE, 32'h0040_0000, 32'h0100_0000);
    send(bpa_pkg::CMD_FREE, 32'd8192, 32'h0000_1000);
    // hand the whole memory to the allocator
    for (int i = 0; i < 4; i++) send(bpa_pkg::CMD_FREE, 32'h0040_0000, i << 22);
    send(bpa_pkg::CMD_FREE, 32'h0040_0000, 32'd0);
    send(bpa_pkg::CMD_ALLOC, 32'd1, 32'd0);
    send(bpa_pkg::CMD_ALLOC, 32'd4096, 32'd0);
    send(bpa_pkg::CMD_ALLOC, 32'd4097, 32'd0);
    send(bpa_pkg::CMD_FREE, 32'd0, 32'h0000_1000);
    send(bpa_pkg::CMD_FREE, 32'd0, 32'd0);
    send(bpa_pkg::CMD_FREE, 32'd4096, 32'd0);
    send(bpa_pkg::CMD_ALLOC, 32'h0040_0000, 32'd0);
    send(bpa_pkg::CMD_ALLOC, 32'h0040_0001, 32'd0);
    for (int i = 0; i < 5; i++) send(bpa_pkg::CMD_ALLOC, 32'h0040_0000, 32'd0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 200 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_REQS / 2) begin
        @(negedge clk_i);
        req_valid_i <= 1'b0;
        wait (pending == 0);
      end
      k = $urandom_range(0, 99);
      if (k < 45 || (k < 85 && owned_q.size() == 0)) begin
        if ($urandom_range(0, 9) < 8) k = $urandom_range(0, 3);
        else k = $urandom_range(4, 10);
        send(bpa_pkg::CMD_ALLOC, size_in_order(k), $urandom());
      end else if (k < 85) begin
        free_owned();
      end else begin
        case ($urandom_range(0, 3))
          0: send(bpa_pkg::CMD_ALLOC, $urandom(), $urandom());
          1: send(bpa_pkg::CMD_FREE, $urandom(), $urandom());
          2: send(bpa_pkg::CMD_FREE, size_in_order(1),
                  ($urandom_range(0, 4095) << 12) | 32'h800);
          default: send(bpa_pkg::CMD_FREE, size_in_order(last_freed.ord), last_freed.addr);
        endcase
      end
    end

    @(negedge clk_i);
    req_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests: allocations with splits, frees with merges,", sent);
    $display("and bad, failed, misaligned and double-free requests.");
    if (fail_count == 0) begin
      $display("buddy_page_allocator_unit test passed");
    end else begin
      $display("buddy_page_allocator_unit test failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_unit.sv
bench/buddy_page_allocator_checker.sv
bench/buddy_page_allocator_unit_tb.sv
